### hw/rtl/xpfec_pkg.sv
// shared types and constants of the xor parity packet fec encoder
// no dependencies; used by xpfec_addr and the top level
package xpfec_pkg;

	localparam int GROUP_SLOTS = 3;
	localparam int SEQ_W       = 32;
	localparam int IDX_W       = 5;
	localparam int WORD_W      = 64;
	localparam int SLOT_W      = 2;

	// input item: seq, index, word, padded to whole bytes
	localparam int S_TDATA_W = 104;
	// result item: seq, index, data, base seq, parity word, padded
	localparam int M_TDATA_W = 200;
	// result flags: parity valid, parity kind
	localparam int M_TUSER_W = 3;

	localparam logic [SLOT_W-1:0] SLOT0 = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT1 = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT2 = 2'd2;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              in_range;
		logic              give_parity;
		logic              eop;
	} ctrl_t;

endpackage

### hw/rtl/xpfec_addr.sv
// slot selection (sequence mod 3) and store address generation
// depends on xpfec_pkg
module xpfec_addr #(
	parameter int WORDS_PER_PACKET = 20,
	parameter int AW               = 6
) (
	input  logic [xpfec_pkg::SEQ_W-1:0] seq_number,
	input  logic [xpfec_pkg::IDX_W-1:0] word_index,
	output xpfec_pkg::ctrl_t            ctrl,
	output logic [AW-1:0]               wr_addr,
	output logic [AW-1:0]               rd_addr
);

	localparam logic [AW-1:0] BASE1 = AW'(WORDS_PER_PACKET);
	localparam logic [AW-1:0] BASE2 = AW'(2 * WORDS_PER_PACKET);

	// 4^k is 1 mod 3, so summing base-4 digits keeps the residue
	function automatic logic [1:0] mod3_32(input logic [31:0] v);
		logic [3:0] grp [4];
		logic [5:0] tot;
		logic [3:0] t2;
		logic [2:0] t3;
		logic [1:0] r;
		for (int g = 0; g < 4; g++) begin
			grp[g] = 4'd0;
			for (int d = 0; d < 4; d++) begin
				grp[g] = grp[g] + 4'(v[g*8 + d*2 +: 2]);
			end
		end
		tot = 6'd0;
		for (int g = 0; g < 4; g++) begin
			tot = tot + 6'(grp[g]);
		end
		t2 = 4'(tot[1:0]) + 4'(tot[3:2]) + 4'(tot[5:4]);
		t3 = 3'(t2[1:0]) + 3'(t2[3:2]);
		case (t3)
			3'd1, 3'd4: r = xpfec_pkg::SLOT1;
			3'd2, 3'd5: r = xpfec_pkg::SLOT2;
			default:    r = xpfec_pkg::SLOT0;
		endcase
		return r;
	endfunction

	logic [1:0]    slot;
	logic          in_range;
	logic          give;
	logic [AW-1:0] wr_base;
	logic [AW-1:0] rd_base;

	always_comb begin
		slot     = mod3_32(seq_number);
		in_range = 32'(word_index) < 32'(WORDS_PER_PACKET);
		give     = in_range && (slot != xpfec_pkg::SLOT0);
		case (slot)
			xpfec_pkg::SLOT1: begin
				wr_base = BASE1;
				rd_base = '0;
			end
			xpfec_pkg::SLOT2: begin
				wr_base = BASE2;
				rd_base = BASE1;
			end
			default: begin
				wr_base = '0;
				rd_base = '0;
			end
		endcase
		// park unused addresses at entry zero
		wr_addr = in_range ? wr_base + AW'(word_index) : '0;
		rd_addr = give ? rd_base + AW'(word_index) : '0;
		ctrl.slot        = slot;
		ctrl.in_range    = in_range;
		ctrl.give_parity = give;
		ctrl.eop         = in_range && (32'(word_index) == 32'(WORDS_PER_PACKET - 1));
	end

endmodule

### hw/rtl/xpfec_store.sv
// payload store: one write and one registered read per cycle while enabled, plus per-entry
// valid bits so that never-written entries read as zero after reset
// no package dependencies
module xpfec_store #(
	parameter int DEPTH  = 60,
	parameter int AW     = 6,
	parameter int WORD_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              we,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else if (en) begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

### hw/rtl/xor_parity_packet_fec_encoder_core.sv
// top level of the xor parity packet fec encoder
// depends on xpfec_pkg, xpfec_addr and xpfec_store
//
// Usage: payload words enter on the s_ channel, one item per word, carrying
// the packet sequence number, the word position and the 64-bit word. Each
// item gives exactly one result on the m_ channel: the word passed through,
// and for in-range words of packets in group slot 1 or 2 a parity word, the
// word held at the same position of the previous slot XORed with this one.
// m_tuser flags the parity and its kind, m_tlast marks the last word of a packet.
// Accepted items pass the first stage register and the output register to
// m_tvalid. One item is accepted every cycle while the output is not stalled;
// the store is read and written in the same stage, one port each, so
// back-to-back items need no forwarding. Reset clears the valid bits of all
// store entries at once, so the store reads as zero and the block accepts
// items as soon as reset is released. When the receiver holds m_tready low
// the result stays in the output register, one more item is taken into the
// first stage, and s_tready then drops until the output moves on.
module xor_parity_packet_fec_encoder_core #(
	parameter int WORDS_PER_PACKET = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// seq_number, word_index, data_word, zero pad
	input  logic [xpfec_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_seq, out_index, out_data, parity_base_seq, parity_word, zero pad
	output logic [xpfec_pkg::M_TDATA_W-1:0]   m_tdata,
	// parity_valid, parity_kind
	output logic [xpfec_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                              m_tlast
);

	localparam int DEPTH = xpfec_pkg::GROUP_SLOTS * WORDS_PER_PACKET;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = xpfec_pkg::SEQ_W;
	localparam int IW    = xpfec_pkg::IDX_W;
	localparam int WW    = xpfec_pkg::WORD_W;
	localparam int MPAD  = xpfec_pkg::M_TDATA_W - (3 * SW / 2 * 0 + 2 * SW + IW + 2 * WW);

	logic [SW-1:0]    in_seq;
	logic [IW-1:0]    in_idx;
	logic [WW-1:0]    in_word;
	xpfec_pkg::ctrl_t in_ctrl;
	logic [AW-1:0]    in_wr_addr;
	logic [AW-1:0]    in_rd_addr;

	logic             valid_s1;
	logic [SW-1:0]    seq_s1;
	logic [IW-1:0]    idx_s1;
	logic [WW-1:0]    word_s1;
	xpfec_pkg::ctrl_t ctrl_s1;
	logic [AW-1:0]    wr_addr_s1;
	logic [AW-1:0]    rd_addr_s1;

	logic             valid_s2;
	logic [SW-1:0]    seq_s2;
	logic [IW-1:0]    idx_s2;
	logic [WW-1:0]    word_s2;
	xpfec_pkg::ctrl_t ctrl_s2;

	logic [WW-1:0]    prev_word;
	logic             adv_s1;
	logic             take;
	logic [SW-1:0]    base_seq;
	logic [WW-1:0]    par_word;

	assign in_seq  = s_tdata[SW-1:0];
	assign in_idx  = s_tdata[SW +: IW];
	assign in_word = s_tdata[SW + IW +: WW];

	xpfec_addr #(
		.WORDS_PER_PACKET(WORDS_PER_PACKET),
		.AW              (AW)
	) u_addr (
		.seq_number(in_seq),
		.word_index(in_idx),
		.ctrl      (in_ctrl),
		.wr_addr   (in_wr_addr),
		.rd_addr   (in_rd_addr)
	);

	// stage 2 frees up when empty or when the result is taken
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seq_s1     <= in_seq;
			idx_s1     <= in_idx;
			word_s1    <= in_word;
			ctrl_s1    <= in_ctrl;
			wr_addr_s1 <= in_wr_addr;
			rd_addr_s1 <= in_rd_addr;
		end
		if (adv_s1) begin
			seq_s2  <= seq_s1;
			idx_s2  <= idx_s1;
			word_s2 <= word_s1;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// store access happens once per item, on its move into stage 2
	xpfec_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.WORD_W(WW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.we     (ctrl_s1.in_range),
		.wr_addr(wr_addr_s1),
		.wr_data(word_s1),
		.rd_addr(rd_addr_s1),
		.rd_data(prev_word)
	);

	always_comb begin
		base_seq = '0;
		par_word = '0;
		if (ctrl_s2.give_parity) begin
			base_seq = seq_s2 - SW'(ctrl_s2.slot);
			par_word = prev_word ^ word_s2;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{MPAD{1'b0}}, par_word, base_seq, word_s2, idx_s2, seq_s2};
	assign m_tuser  = {ctrl_s2.give_parity ? ctrl_s2.slot : xpfec_pkg::SLOT0,
		ctrl_s2.give_parity};
	assign m_tlast  = ctrl_s2.eop;

endmodule

### tb/testbench.sv
// self-checking testbench for xor_parity_packet_fec_encoder_core
// needs xpfec_pkg and the encoder rtl; keeps its own copy of the payload store
// and checks every result item against a predicted one, in order
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WPP         = 20;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int IW          = xpfec_pkg::IDX_W;
	localparam int SLW         = xpfec_pkg::SLOT_W;

	typedef struct packed {
		logic [xpfec_pkg::SEQ_W-1:0]  seq;
		logic [xpfec_pkg::IDX_W-1:0]  idx;
		logic [xpfec_pkg::WORD_W-1:0] data;
		logic                         par_valid;
		logic [xpfec_pkg::SEQ_W-1:0]  base;
		logic [xpfec_pkg::SLOT_W-1:0] kind;
		logic [xpfec_pkg::WORD_W-1:0] par_word;
		logic                         eop;
	} fec_result_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [xpfec_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [xpfec_pkg::M_TDATA_W-1:0] m_tdata;
	logic [xpfec_pkg::M_TUSER_W-1:0] m_tuser;
	logic                            m_tlast;

	logic [xpfec_pkg::WORD_W-1:0] payload_copy [xpfec_pkg::GROUP_SLOTS*WPP];
	fec_result_t                  fec_expected [$];

	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned parity_seen  = 0;
	int unsigned outside_seen = 0;
	int unsigned bad_results  = 0;
	int unsigned cycle_count  = 0;
	bit          tx_idle      = 1'b0;
	bit          rx_idle      = 1'b0;
	int          hold_req     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	xor_parity_packet_fec_encoder_core #(
		.WORDS_PER_PACKET(WPP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// updates the store copy and works out the result of one item
	function automatic fec_result_t predict_fec(input logic [xpfec_pkg::SEQ_W-1:0] seq,
			input logic [xpfec_pkg::IDX_W-1:0] idx,
			input logic [xpfec_pkg::WORD_W-1:0] word);
		fec_result_t                  r;
		logic [xpfec_pkg::SLOT_W-1:0] slot;
		slot = SLW'(seq % xpfec_pkg::GROUP_SLOTS);
		r = '0;
		r.seq  = seq;
		r.idx  = idx;
		r.data = word;
		if (idx < WPP) begin
			payload_copy[slot*WPP + idx] = word;
			r.eop = (idx == WPP-1);
			if (slot != xpfec_pkg::SLOT0) begin
				r.par_valid = 1'b1;
				r.base      = seq - slot;
				r.kind      = slot;
				r.par_word  = payload_copy[(slot-1)*WPP + idx] ^ word;
			end
		end
		return r;
	endfunction

	function automatic logic [xpfec_pkg::WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly the least gap asked for, otherwise a short, a middling or now and then a long gap
	function automatic int pick_gap(input int least);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return least;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic [xpfec_pkg::SEQ_W-1:0] seq,
			input logic [xpfec_pkg::IDX_W-1:0] idx,
			input logic [xpfec_pkg::WORD_W-1:0] word);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, word, idx, seq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fec_expected.push_back(predict_fec(seq, idx, word));
		items_sent++;
		gap = tx_idle ? pick_gap(0) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_packet(input logic [xpfec_pkg::SEQ_W-1:0] seq, input int words);
		for (int i = 0; i < words; i++)
			send_word(seq, IW'(i), rand_word());
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (fec_expected.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		// slot one before anything is stored: parity against zero
		send_word(32'd1, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(32'd0, 5'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(32'd1, 5'd0, 64'h5555_5555_5555_5555);
		send_word(32'd2, 5'd0, 64'h0);
		// group at the top of the sequence range, last word of the packet
		send_word(32'hFFFF_FFFF, 5'd19, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(32'hFFFF_FFFC, 5'd19, 64'h0F0F_0F0F_0F0F_0F0F);
		send_word(32'hFFFF_FFFD, 5'd19, 64'h0123_4567_89AB_CDEF);
		send_word(32'hFFFF_FFFE, 5'd19, 64'h0);
		// index past the packet end: forwarded only, then an in-range word of slot one
		send_word(32'd3, 5'd20, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(32'd4, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(32'd5, 5'd31, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(32'd4, 5'd19, 64'h1111_2222_3333_4444);
		// slot two with the slot one entry never written
		send_word(32'd6, 5'd5, 64'hDEAD_BEEF_0000_FFFF);
		send_word(32'd8, 5'd5, 64'h8000_0000_0000_0001);
		send_word(32'd7, 5'd5, 64'h7FFF_FFFF_FFFF_FFFE);
		send_word(32'd8, 5'd5, 64'hC3C3_C3C3_3C3C_3C3C);
		drain_results();
	endtask

	task automatic test_back_pressure();
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		hold_req = 150;
		send_packet(32'd30, WPP);
		send_packet(32'd31, WPP);
		drain_results();
	endtask

	task automatic test_sender_pause();
		logic [xpfec_pkg::SEQ_W-1:0] base;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		base = $urandom;
		base = base - base % xpfec_pkg::GROUP_SLOTS;
		for (int p = 0; p < xpfec_pkg::GROUP_SLOTS; p++) begin
			send_packet(base + p, WPP);
			drain_results();
		end
	endtask

	task automatic test_random_groups();
		logic [xpfec_pkg::SEQ_W-1:0] base;
		int unsigned                 start;
		int                          pick;
		start = items_sent;
		while (items_sent - start < 810) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			base = $urandom;
			base = base - base % xpfec_pkg::GROUP_SLOTS;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				for (int p = 0; p < xpfec_pkg::GROUP_SLOTS; p++)
					send_packet(base + p, WPP);
			end else if (pick < 9) begin
				// packets out of order, repeated or cut short
				repeat (xpfec_pkg::GROUP_SLOTS)
					send_packet(base + $urandom_range(0, 2), $urandom_range(1, WPP));
			end else begin
				repeat ($urandom_range(1, 12))
					send_word($urandom, IW'($urandom_range(0, 31)), rand_word());
			end
		end
	endtask

	// receiver: a long hold when asked, otherwise random stalls while rx_idle is set
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req > 0) begin
				m_tready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap(1)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic bit field_differs(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want === got)
			return 1'b0;
		$error("%s: expected %h, got %h", name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		fec_result_t want;
		fec_result_t got;
		bit          bad;
		if (arst_n && m_tvalid && m_tready) begin
			got.seq       = m_tdata[31:0];
			got.idx       = m_tdata[36:32];
			got.data      = m_tdata[100:37];
			got.base      = m_tdata[132:101];
			got.par_word  = m_tdata[196:133];
			got.par_valid = m_tuser[0];
			got.kind      = m_tuser[2:1];
			got.eop       = m_tlast;
			results_seen++;
			if (fec_expected.size() == 0) begin
				$error("result item with nothing expected, seq %h", got.seq);
				bad_results++;
			end else begin
				want = fec_expected.pop_front();
				if (want.par_valid)
					parity_seen++;
				if (want.idx >= WPP)
					outside_seen++;
				bad = field_differs("out_seq", 64'(want.seq), 64'(got.seq))
					| field_differs("out_index", 64'(want.idx), 64'(got.idx))
					| field_differs("out_data", want.data, got.data)
					| field_differs("parity_valid", 64'(want.par_valid),
						64'(got.par_valid))
					| field_differs("parity_base_seq", 64'(want.base), 64'(got.base))
					| field_differs("parity_kind", 64'(want.kind), 64'(got.kind))
					| field_differs("parity_word", want.par_word, got.par_word)
					| field_differs("end_of_packet", 64'(want.eop), 64'(got.eop));
				if (bad)
					bad_results++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding",
				cycle_count, fec_expected.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		foreach (payload_copy[i])
			payload_copy[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_sender_pause();
		test_random_groups();
		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d items sent, %0d results checked: %0d carrying parity, %0d past packet end",
			items_sent, results_seen, parity_seen, outside_seen);
		$display("%0d results failed their check", bad_results);
		if (bad_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
